// ===== src/ipv4_tcp_udp_header_classifier_defines.svh =====
// Assertion macros for the IPv4 TCP/UDP header classifier.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef IPV4_TCP_UDP_HEADER_CLASSIFIER_DEFINES_SVH
`define IPV4_TCP_UDP_HEADER_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IPHC_ASSERT_NOW(name, trig, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IPHC_ASSERT_NEXT(name, trig, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

// ===== src/iphc_pkg.sv =====
// Shared types, constants and helpers for the IPv4 TCP/UDP header classifier.
// No dependencies; imported by iphc_parser, iphc_record and the top level.
package iphc_pkg;

    localparam int POS_W           = 17;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int ETH_HDR_BYTES   = 14;

    localparam logic [POS_W-1:0] POS_MAX      = 17'h1FFFF;
    localparam logic [POS_W-1:0] POS_ETYPE_HI = 17'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO = 17'd13;
    localparam logic [POS_W-1:0] POS_IHL      = 17'd14;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd16;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd17;
    localparam logic [POS_W-1:0] POS_PROTO    = 17'd23;
    localparam logic [POS_W-1:0] POS_SRC_FIRST = 17'd26;
    localparam logic [POS_W-1:0] POS_SRC_LAST  = 17'd29;
    localparam logic [POS_W-1:0] POS_DST_FIRST = 17'd30;
    localparam logic [POS_W-1:0] POS_DST_LAST  = 17'd33;

    // Offsets into the transport header
    localparam logic [POS_W-1:0] TOFF_PORTS_END = 17'd4;
    localparam logic [POS_W-1:0] TOFF_DOFF      = 17'd12;
    localparam logic [POS_W-1:0] TOFF_FLAGS     = 17'd13;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [6:0]  UDP_HDR_BYTES  = 7'd8;
    localparam logic [15:0] CSUM_ALL_ONES  = 16'hFFFF;

    typedef enum logic [1:0] {
        CLASS_NON_IP = 2'd0,
        CLASS_TCP    = 2'd1,
        CLASS_UDP    = 2'd2,
        CLASS_OTHER  = 2'd3
    } iphc_class_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } iphc_in_t;

    typedef struct packed {
        logic [1:0]  packet_class;
        logic        checksum_ok;
        logic        truncated;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  tcp_flag_bits;
        logic [15:0] payload_bytes;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [31:0] tcp_total;
        logic [31:0] udp_total;
        logic [31:0] other_ip_total;
    } iphc_out_t;

    // Per-frame header state as it stands after the current beat
    typedef struct packed {
        logic [POS_W-1:0] last_pos;
        logic [15:0]      etype;
        logic [3:0]       ihl;
        logic [15:0]      ip_len;
        logic [7:0]       proto;
        logic [31:0]      src_ip;
        logic [31:0]      dst_ip;
        logic [31:0]      ports;
        logic [3:0]       doff;
        logic [7:0]       flags;
        logic [17:0]      csum_raw;   // unfolded segment + pseudo-header sum
    } iphc_frame_t;

    // Header length in bytes from a 32-bit-word count, floor of five words
    function automatic logic [5:0] hdr_bytes(input logic [3:0] words);
        hdr_bytes = (words < 4'd5) ? 6'd20 : {words, 2'b00};
    endfunction

endpackage

// ===== src/ipv4_tcp_udp_header_classifier.sv =====
// IPv4 TCP/UDP header classifier: one frame byte per beat in, one record per frame out.
// Throughput: one byte per cycle; a byte is accepted every cycle unless a held last byte waits for the record slot.
// A frame's last byte is registered on accept and parsed once the record slot is free; its
// record is then captured in the result register, which raises rec_valid.
// Reset (rst_n, async, active low) clears frame state, class counters and both valids.
// Depends on iphc_pkg, iphc_parser, iphc_record and the defines header.
`include "ipv4_tcp_udp_header_classifier_defines.svh"

module ipv4_tcp_udp_header_classifier
    import iphc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF   // 8 to 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  iphc_in_t  byte_data,
    output logic      rec_valid,
    input  logic      rec_ready,
    output iphc_out_t rec_data
);

    logic        in_valid_reg, in_valid_next;
    iphc_in_t    in_beat_reg;
    logic        accept;
    logic        rec_free;
    logic        proc_fire;
    logic        take;
    iphc_frame_t frame;

    // a last-byte beat waits only when the record slot is still full
    assign rec_free   = !rec_valid || rec_ready;
    assign proc_fire  = in_valid_reg && (!in_beat_reg.end_of_frame || rec_free);
    assign take       = proc_fire && in_beat_reg.end_of_frame;
    assign byte_ready = !in_valid_reg || proc_fire;
    assign accept     = byte_valid && byte_ready;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (proc_fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_beat_reg <= byte_data;
    end

    iphc_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (in_beat_reg),
        .fire  (proc_fire),
        .frame (frame)
    );

    iphc_record #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_record (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame),
        .take      (take),
        .rec_ready (rec_ready),
        .rec_valid (rec_valid),
        .rec_data  (rec_data)
    );

    `IPHC_ASSERT_NEXT(a_eof_makes_record, take, rec_valid, "last byte did not produce a record")
    `IPHC_ASSERT_NEXT(a_eof_held_on_stall, in_valid_reg && in_beat_reg.end_of_frame && rec_valid && !rec_ready, in_valid_reg, "stalled last byte was dropped")
    `IPHC_ASSERT_NOW(a_ok_only_full_tcp, rec_valid && rec_data.checksum_ok, (rec_data.packet_class == CLASS_TCP) && !rec_data.truncated, "checksum_ok outside complete TCP")
    `IPHC_ASSERT_NOW(a_non_ip_zeroed, rec_valid && (rec_data.packet_class == CLASS_NON_IP), (rec_data.source_ip == 32'd0) && (rec_data.source_port == 16'd0) && (rec_data.payload_bytes == 16'd0), "non-IPv4 record carries header fields")

endmodule

// ===== src/iphc_parser.sv =====
// Byte-position parser: captures header fields and runs the TCP checksum sum.
// Depends on iphc_pkg.
module iphc_parser
    import iphc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iphc_in_t    beat,
    input  logic        fire,
    output iphc_frame_t frame
);

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [15:0]      etype_reg, etype_next;
    logic [3:0]       ihl_reg,   ihl_next;
    logic [15:0]      len_reg,   len_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      src_reg,   src_next;
    logic [31:0]      dst_reg,   dst_next;
    logic [31:0]      ports_reg, ports_next;
    logic [3:0]       doff_reg,  doff_next;
    logic [7:0]       flags_reg, flags_next;
    logic [15:0]      acc_reg,   acc_next;
    logic [7:0]       held_reg,  held_next;

    logic [7:0]       b;
    logic [5:0]       hl;
    logic [6:0]       start;
    logic             in_hdr;
    logic [POS_W-1:0] t;
    logic [POS_W-1:0] seg_end;
    logic             in_seg;
    logic [15:0]      seg;
    logic             pseudo;
    logic [15:0]      word_add;
    logic [16:0]      acc_sum;
    logic [15:0]      pad;

    always_comb
    begin
        b       = beat.frame_byte;
        hl      = hdr_bytes(ihl_reg);
        start   = 7'(ETH_HDR_BYTES) + {1'b0, hl};
        in_hdr  = pos_reg >= {10'b0, start};
        t       = pos_reg - {10'b0, start};
        // segment spans [start, 14 + ip_len); empty when ip_len <= header length
        seg_end = 17'(ETH_HDR_BYTES) + {1'b0, len_reg};
        in_seg  = in_hdr && (pos_reg < seg_end);
        seg     = (len_reg > {10'b0, hl}) ? (len_reg - {10'b0, hl}) : 16'd0;
        // pseudo-header address words close on the odd address bytes
        pseudo  = (pos_reg == 17'd27) || (pos_reg == 17'd29) ||
                  (pos_reg == 17'd31) || (pos_reg == POS_DST_LAST);

        etype_next = etype_reg;
        ihl_next   = ihl_reg;
        len_next   = len_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        ports_next = ports_reg;
        doff_next  = doff_reg;
        flags_next = flags_reg;
        held_next  = held_reg;
        word_add   = 16'd0;

        if (pos_reg == POS_ETYPE_HI)
            etype_next[15:8] = b;
        else if (pos_reg == POS_ETYPE_LO)
            etype_next[7:0] = b;
        else if (pos_reg == POS_IHL)
            ihl_next = b[3:0];
        else if (pos_reg == POS_LEN_HI)
            len_next[15:8] = b;
        else if (pos_reg == POS_LEN_LO)
            len_next[7:0] = b;
        else if (pos_reg == POS_PROTO)
            proto_next = b;
        else if (pos_reg >= POS_SRC_FIRST && pos_reg <= POS_SRC_LAST)
            src_next = {src_reg[23:0], b};
        else if (pos_reg >= POS_DST_FIRST && pos_reg <= POS_DST_LAST)
            dst_next = {dst_reg[23:0], b};

        if (pseudo)
            word_add = {(pos_reg < POS_DST_FIRST) ? src_reg[7:0] : dst_reg[7:0], b};

        if (in_hdr)
        begin
            if (t < TOFF_PORTS_END)
                ports_next = {ports_reg[23:0], b};
            else if (t == TOFF_DOFF)
                doff_next = b[7:4];
            else if (t == TOFF_FLAGS)
                flags_next = b;
        end

        // start is even, so segment word parity follows the byte position
        if (in_seg)
        begin
            if (!pos_reg[0])
                held_next = b;
            else
                word_add = {held_reg, b};
        end

        acc_sum  = {1'b0, acc_reg} + {1'b0, word_add};
        acc_next = acc_sum[15:0] + {15'd0, acc_sum[16]};

        pad = seg[0] ? {held_next, 8'h00} : 16'd0;

        if (pos_reg < POS_MAX)
            pos_next = pos_reg + 17'd1;
        else
            pos_next = pos_reg;

        frame.last_pos   = pos_reg;
        frame.etype      = etype_next;
        frame.ihl        = ihl_next;
        frame.ip_len     = len_next;
        frame.proto      = proto_next;
        frame.src_ip     = src_next;
        frame.dst_ip     = dst_next;
        frame.ports      = ports_next;
        frame.doff       = doff_next;
        frame.flags      = flags_next;
        // end-around sum is only compared mod 0xFFFF, so terms may be reordered
        frame.csum_raw   = {2'b0, acc_reg} + {2'b0, word_add} + {2'b0, pad} +
                           {2'b0, seg} + {2'b0, 8'd0, PROTO_TCP};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            etype_reg <= '0;
            ihl_reg   <= '0;
            len_reg   <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            ports_reg <= '0;
            doff_reg  <= '0;
            flags_reg <= '0;
            acc_reg   <= '0;
            held_reg  <= '0;
        end
        else if (fire)
        begin
            if (beat.end_of_frame)
            begin
                pos_reg   <= '0;
                etype_reg <= '0;
                ihl_reg   <= '0;
                len_reg   <= '0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
                ports_reg <= '0;
                doff_reg  <= '0;
                flags_reg <= '0;
                acc_reg   <= '0;
                held_reg  <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                etype_reg <= etype_next;
                ihl_reg   <= ihl_next;
                len_reg   <= len_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                ports_reg <= ports_next;
                doff_reg  <= doff_next;
                flags_reg <= flags_next;
                acc_reg   <= acc_next;
                held_reg  <= held_next;
            end
        end
    end

endmodule

// ===== src/iphc_record.sv =====
// Frame-end record builder: class, truncation, payload size, checksum verdict,
// saturating class counters and the result register. Depends on iphc_pkg.
module iphc_record
    import iphc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  iphc_frame_t frame,
    input  logic        take,
    input  logic        rec_ready,
    output logic        rec_valid,
    output iphc_out_t   rec_data
);

    logic                   valid_reg, valid_next;
    iphc_out_t              res_reg,   res_next;
    logic [COUNT_WIDTH-1:0] cnt_reg  [3];
    logic [COUNT_WIDTH-1:0] cnt_next [3];

    logic [POS_W:0]         len;
    logic                   short_frame;
    logic                   ipv4;
    iphc_class_t            cls;
    logic [1:0]             cidx;
    logic [5:0]             hl;
    logic [6:0]             thl;
    logic [6:0]             hdrs;
    logic [15:0]            need_body;
    logic [POS_W-1:0]       need;
    logic                   trunc;
    logic [15:0]            pay;
    logic [16:0]            f1;
    logic [15:0]            f2;
    logic                   ports_valid;
    logic [COUNT_WIDTH+31:0] wide [3];

    always_comb
    begin
        len         = {1'b0, frame.last_pos} + 18'd1;
        short_frame = len < 18'(ETH_HDR_BYTES);
        ipv4        = !short_frame && (frame.etype == ETHERTYPE_IPV4);
        hl          = hdr_bytes(frame.ihl);

        if (frame.proto == PROTO_TCP)
        begin
            cls = CLASS_TCP;
            thl = {1'b0, hdr_bytes(frame.doff)};
        end
        else if (frame.proto == PROTO_UDP)
        begin
            cls = CLASS_UDP;
            thl = UDP_HDR_BYTES;
        end
        else
        begin
            cls = CLASS_OTHER;
            thl = 7'd0;
        end

        cidx = (cls == CLASS_TCP) ? 2'd0 : ((cls == CLASS_UDP) ? 2'd1 : 2'd2);

        hdrs      = {1'b0, hl} + thl;
        need_body = ({9'd0, hdrs} > frame.ip_len) ? {9'd0, hdrs} : frame.ip_len;
        need      = 17'(ETH_HDR_BYTES) + {1'b0, need_body};
        trunc     = short_frame || (ipv4 && (len < {1'b0, need}));
        pay       = (frame.ip_len > {9'd0, hdrs}) ? (frame.ip_len - {9'd0, hdrs}) : 16'd0;

        f1 = {1'b0, frame.csum_raw[15:0]} + {15'd0, frame.csum_raw[17:16]};
        f2 = f1[15:0] + {15'd0, f1[16]};

        for (int k = 0; k < 3; k++)
        begin
            cnt_next[k] = cnt_reg[k];
            if (take && ipv4 && (cidx == 2'(k)) && (cnt_reg[k] != '1))
                cnt_next[k] = cnt_reg[k] + COUNT_WIDTH'(1);
            wide[k] = {32'd0, cnt_next[k]};
        end

        ports_valid = ipv4 && (cls != CLASS_OTHER);

        res_next.packet_class   = ipv4 ? cls : CLASS_NON_IP;
        res_next.checksum_ok    = ipv4 && (cls == CLASS_TCP) && !trunc && (f2 == CSUM_ALL_ONES);
        res_next.truncated      = trunc;
        res_next.source_port    = ports_valid ? frame.ports[31:16] : 16'd0;
        res_next.dest_port      = ports_valid ? frame.ports[15:0] : 16'd0;
        res_next.tcp_flag_bits  = (ipv4 && (cls == CLASS_TCP)) ? frame.flags : 8'd0;
        res_next.payload_bytes  = ipv4 ? pay : 16'd0;
        res_next.source_ip      = ipv4 ? frame.src_ip : 32'd0;
        res_next.dest_ip        = ipv4 ? frame.dst_ip : 32'd0;
        res_next.tcp_total      = wide[0][31:0];
        res_next.udp_total      = wide[1][31:0];
        res_next.other_ip_total = wide[2][31:0];

        if (take)
            valid_next = 1'b1;
        else if (rec_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
                cnt_reg[k] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            for (int k = 0; k < 3; k++)
                cnt_reg[k] <= cnt_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    assign rec_valid = valid_reg;
    assign rec_data  = res_reg;

endmodule
